/* src/srtf_pkg.sv */
// shared types and constants for the srtf scheduler
package srtf_pkg;

    localparam int NUM_JOBS_DEF = 16;

    typedef enum logic [1:0] {
        ST_ADD_OK   = 2'd0,
        ST_ADD_FULL = 2'd1,
        ST_ADD_ZERO = 2'd2,
        ST_TICK     = 2'd3
    } srtf_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } srtf_state_t;

    // token that walks the slot chain once per beat
    // hit means slot claimed (or zero burst) on add, or a candidate held on tick
    typedef struct packed {
        logic        active;
        logic        is_tick;
        logic        hit;
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [15:0] order;
    } srtf_tok_t;

endpackage

/* src/srtf_if.sv */
// valid/ready channel interfaces for job and result beats
interface srtf_job_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  job_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;

    modport source (output valid, mode, job_id, arrival_time, burst_length, input ready);
    modport sink   (input valid, mode, job_id, arrival_time, burst_length, output ready);
endinterface

interface srtf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        idle;
    logic [7:0]  run_id;
    logic [31:0] slice_start;
    logic        job_finished;

    modport source (output valid, status, idle, run_id, slice_start, job_finished, input ready);
    modport sink   (input valid, status, idle, run_id, slice_start, job_finished, output ready);
endinterface

/* src/srtf_cell.sv */
// one job slot of the scheduler chain with its compare and claim logic
module srtf_cell
    import srtf_pkg::*;
#(
    parameter int NUM_JOBS = NUM_JOBS_DEF,
    parameter int CELL_IDX = 0
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  srtf_tok_t                   tok_in,
    input  logic [$clog2(NUM_JOBS)-1:0] idx_in,
    output srtf_tok_t                   tok_out,
    output logic [$clog2(NUM_JOBS)-1:0] idx_out,
    input  logic [31:0]                 now,
    input  logic                        dec_en,
    input  logic [$clog2(NUM_JOBS)-1:0] dec_idx
);

    localparam int IDX_W = $clog2(NUM_JOBS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  id_reg;
    logic [15:0] arr_reg;
    logic [15:0] rem_reg;
    logic [15:0] ord_reg;

    srtf_tok_t        tok_reg;
    srtf_tok_t        tok_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic eligible;
    logic better;
    logic claim;
    logic take;
    logic dec_hit;

    always_comb
    begin
        eligible = valid_reg && ({16'd0, arr_reg} <= now);
        better   = (rem_reg < tok_in.remaining)
                || ((rem_reg == tok_in.remaining) && (arr_reg < tok_in.arrival))
                || ((rem_reg == tok_in.remaining) && (arr_reg == tok_in.arrival)
                    && (ord_reg < tok_in.order));
        claim    = tok_in.active && !tok_in.is_tick && !tok_in.hit && !valid_reg;
        take     = tok_in.active && tok_in.is_tick && eligible && (!tok_in.hit || better);
        dec_hit  = dec_en && (dec_idx == MY_IDX);

        tok_next = tok_in;
        idx_next = idx_in;
        if (claim)
        begin
            tok_next.hit = 1'b1;
        end
        if (take)
        begin
            tok_next.hit       = 1'b1;
            tok_next.id        = id_reg;
            tok_next.arrival   = arr_reg;
            tok_next.remaining = rem_reg;
            tok_next.order     = ord_reg;
            idx_next           = MY_IDX;
        end

        valid_next = valid_reg;
        if (claim)
        begin
            valid_next = 1'b1;
        end
        else if (dec_hit && (rem_reg == 16'd1))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (claim)
        begin
            id_reg  <= tok_in.id;
            arr_reg <= tok_in.arrival;
            rem_reg <= tok_in.remaining;
            ord_reg <= tok_in.order;
        end
        else if (dec_hit)
        begin
            rem_reg <= rem_reg - 16'd1;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

/* src/srtf_process_scheduler.sv */
// shortest-remaining-time-first scheduler top level: control and slot chain
//
//   channel   dir   beat contents
//   jobs      in    mode, job_id, arrival_time, burst_length
//   results   out   status, idle, run_id, slice_start, job_finished
//
// every beat sends a token along the chain of slot cells, one cell per cycle,
// then the done state settles the winner and writes the result
// a tick decrements the chosen slot in the same cycle its result is registered
// reset clears slot valid bits, time and add count at once; no clearing pass
// jobs.ready is high only between beats; a stalled result holds the finish step
module srtf_process_scheduler
    import srtf_pkg::*;
#(
    parameter int NUM_JOBS = NUM_JOBS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    srtf_job_if.sink       jobs,
    srtf_res_if.source     results
);

    localparam int IDX_W = $clog2(NUM_JOBS);

    srtf_tok_t        tok_chain [NUM_JOBS+1];
    logic [IDX_W-1:0] idx_chain [NUM_JOBS+1];

    srtf_state_t state_reg;
    srtf_state_t state_next;
    logic [31:0] time_reg;
    logic [31:0] time_next;
    logic [15:0] add_cnt_reg;
    logic [15:0] add_cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    srtf_tok_t        res_tok_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             zero_reg;

    srtf_status_t status_reg;
    logic         idle_reg;
    logic [7:0]   run_id_reg;
    logic [31:0]  slice_reg;
    logic         fin_reg;

    srtf_status_t status_val;
    logic         accept;
    logic         load;
    logic         dec_en;
    logic         ran;

    // token entering the first cell
    always_comb
    begin
        tok_chain[0].active    = accept;
        tok_chain[0].is_tick   = jobs.mode;
        tok_chain[0].hit       = !jobs.mode && (jobs.burst_length == 16'd0);
        tok_chain[0].id        = jobs.job_id;
        tok_chain[0].arrival   = jobs.arrival_time;
        tok_chain[0].remaining = jobs.burst_length;
        tok_chain[0].order     = add_cnt_reg;
        idx_chain[0]           = '0;
    end

    for (genvar g = 0; g < NUM_JOBS; g++)
    begin : g_cell
        srtf_cell #(
            .NUM_JOBS (NUM_JOBS),
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g]),
            .idx_in  (idx_chain[g]),
            .tok_out (tok_chain[g+1]),
            .idx_out (idx_chain[g+1]),
            .now     (time_reg),
            .dec_en  (dec_en),
            .dec_idx (res_idx_reg)
        );
    end

    always_comb
    begin
        jobs.ready     = (state_reg == S_IDLE);
        accept         = jobs.valid && jobs.ready;
        load           = 1'b0;
        state_next     = state_reg;
        time_next      = time_reg;
        add_cnt_next   = add_cnt_reg;
        ran            = res_tok_reg.is_tick && res_tok_reg.hit;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_chain[NUM_JOBS].active)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (res_tok_reg.is_tick)
                    begin
                        time_next = time_reg + 32'd1;
                    end
                    else if (res_tok_reg.hit && !zero_reg)
                    begin
                        add_cnt_next = add_cnt_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        dec_en = load && ran;

        if (res_tok_reg.is_tick)
        begin
            status_val = ST_TICK;
        end
        else if (zero_reg)
        begin
            status_val = ST_ADD_ZERO;
        end
        else if (res_tok_reg.hit)
        begin
            status_val = ST_ADD_OK;
        end
        else
        begin
            status_val = ST_ADD_FULL;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= 32'd0;
            add_cnt_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            add_cnt_reg   <= add_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zero_reg <= !jobs.mode && (jobs.burst_length == 16'd0);
        end
        if ((state_reg == S_SCAN) && tok_chain[NUM_JOBS].active)
        begin
            res_tok_reg <= tok_chain[NUM_JOBS];
            res_idx_reg <= idx_chain[NUM_JOBS];
        end
        if (load)
        begin
            status_reg <= status_val;
            idle_reg   <= res_tok_reg.is_tick && !res_tok_reg.hit;
            run_id_reg <= ran ? res_tok_reg.id : 8'd0;
            slice_reg  <= res_tok_reg.is_tick ? time_reg : 32'd0;
            fin_reg    <= ran && (res_tok_reg.remaining == 16'd1);
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.idle         = idle_reg;
    assign results.run_id       = run_id_reg;
    assign results.slice_start  = slice_reg;
    assign results.job_finished = fin_reg;

endmodule

/* dv/srtf_process_scheduler_tb.sv */
// testbench for the srtf scheduler: random job/tick beats checked against a slot predictor
module srtf_process_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    localparam int SLOTS = NUM_JOBS_DEF;
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int RANDOM_BEATS = 1200;
    localparam int PARK_CAP = 4;
    localparam int STALL_CYCLES = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic        mode;
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } job_beat_t;

    typedef struct {
        srtf_status_t status;
        logic         idle;
        logic [7:0]   run_id;
        logic [31:0]  slice_start;
        logic         finished;
    } sched_result_t;

    class srtf_scoreboard;
        bit            used [SLOTS];
        logic [7:0]    ids [SLOTS];
        logic [15:0]   arrival [SLOTS];
        logic [15:0]   remaining [SLOTS];
        logic [15:0]   order [SLOTS];
        logic [15:0]   add_count;
        logic [31:0]   now;
        sched_result_t due_results [$];
        int            errors;
        int            beats_checked;

        function new();
            foreach (used[k])
                used[k] = 1'b0;
            add_count = '0;
            now = '0;
            errors = 0;
            beats_checked = 0;
        endfunction

        // shorter remaining, then earlier arrival, then earlier add
        function bit preferred(int a, int b);
            if (remaining[a] != remaining[b])
                return remaining[a] < remaining[b];
            if (arrival[a] != arrival[b])
                return arrival[a] < arrival[b];
            return order[a] < order[b];
        endfunction

        function sched_result_t schedule_step(job_beat_t j);
            sched_result_t r;
            int            pick;
            r.status = ST_TICK;
            r.idle = 1'b0;
            r.run_id = '0;
            r.slice_start = '0;
            r.finished = 1'b0;
            pick = -1;
            if (j.mode == MODE_ADD)
            begin
                if (j.burst == 16'd0)
                    r.status = ST_ADD_ZERO;
                else
                begin
                    for (int k = 0; k < SLOTS; k++)
                        if (!used[k] && pick < 0)
                            pick = k;
                    if (pick < 0)
                        r.status = ST_ADD_FULL;
                    else
                    begin
                        used[pick] = 1'b1;
                        ids[pick] = j.id;
                        arrival[pick] = j.arrival;
                        remaining[pick] = j.burst;
                        order[pick] = add_count;
                        add_count = add_count + 16'd1;
                        r.status = ST_ADD_OK;
                    end
                end
            end
            else
            begin
                for (int k = 0; k < SLOTS; k++)
                    if (used[k] && {16'd0, arrival[k]} <= now
                        && (pick < 0 || preferred(k, pick)))
                        pick = k;
                r.slice_start = now;
                if (pick < 0)
                    r.idle = 1'b1;
                else
                begin
                    r.run_id = ids[pick];
                    remaining[pick] = remaining[pick] - 16'd1;
                    if (remaining[pick] == 16'd0)
                    begin
                        used[pick] = 1'b0;
                        r.finished = 1'b1;
                    end
                end
                now = now + 32'd1;
            end
            return r;
        endfunction

        function void take_job(job_beat_t j);
            due_results.insert(due_results.size(), schedule_step(j));
        endfunction

        // jobs that arrive more than 64 ahead of now or have over 64 remaining
        function int parked();
            int n;
            n = 0;
            for (int k = 0; k < SLOTS; k++)
                if (used[k] && ({16'd0, arrival[k]} > now + 32'd64 || remaining[k] > 16'd64))
                    n++;
            return n;
        endfunction

        task flag(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch at result beat %0d: %s", beats_checked, msg);
        endtask

        task match_result(sched_result_t got);
            sched_result_t want;
            if (due_results.size() == 0)
            begin
                flag("result beat with nothing expected");
                beats_checked++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status)
                flag($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.idle !== want.idle)
                flag($sformatf("idle %0b, expected %0b", got.idle, want.idle));
            if (got.run_id !== want.run_id)
                flag($sformatf("run_id %0h, expected %0h", got.run_id, want.run_id));
            if (got.slice_start !== want.slice_start)
                flag($sformatf("slice_start %0d, expected %0d", got.slice_start,
                               want.slice_start));
            if (got.finished !== want.finished)
                flag($sformatf("job_finished %0b, expected %0b", got.finished, want.finished));
            beats_checked++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    bit   calm = 1'b0;
    bit   stall_req = 1'b0;

    srtf_scoreboard sb;

    srtf_job_if jobs ();
    srtf_res_if results ();

    srtf_process_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (jobs),
        .results (results)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL srtf_process_scheduler");
            $finish;
        end
    end

    function automatic job_beat_t mk(logic mode, logic [7:0] id, logic [15:0] arr,
                                     logic [15:0] burst);
        job_beat_t j;
        j.mode = mode;
        j.id = id;
        j.arrival = arr;
        j.burst = burst;
        return j;
    endfunction

    function automatic job_beat_t random_job(bit add_heavy);
        job_beat_t j;
        int        pct;
        int        a;
        j.id = 8'($urandom);
        j.arrival = 16'($urandom);
        j.burst = 16'($urandom);
        j.mode = ($urandom_range(0, 99) < (add_heavy ? 70 : 15)) ? MODE_ADD : MODE_TICK;
        if (j.mode == MODE_ADD)
        begin
            pct = $urandom_range(0, 99);
            if (pct < 3)
                j.burst = 16'd0;
            else if (pct < 6 && sb.parked() < PARK_CAP)
                j.burst = 16'($urandom_range(1, 65535));
            else
            begin
                // arrivals close to now, some already in the past
                a = int'(sb.now) + int'($urandom_range(0, 10)) - int'($urandom_range(0, 12));
                if (a < 0)
                    a = 0;
                j.arrival = 16'(a);
                j.burst = (pct < 15) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6));
            end
        end
        return j;
    endfunction

    task automatic send_job(job_beat_t j);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            jobs.valid <= 1'b0;
            @(posedge clk);
        end
        jobs.valid <= 1'b1;
        jobs.mode <= j.mode;
        jobs.job_id <= j.id;
        jobs.arrival_time <= j.arrival;
        jobs.burst_length <= j.burst;
        @(posedge clk);
        while (jobs.ready !== 1'b1)
            @(posedge clk);
        sb.take_job(j);
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        jobs.valid <= 1'b0;
        jobs.mode <= MODE_ADD;
        jobs.job_id <= '0;
        jobs.arrival_time <= '0;
        jobs.burst_length <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_job(mk(MODE_TICK, 8'h00, 16'h0000, 16'h0000));   // empty table
        send_job(mk(MODE_ADD, 8'h00, 16'h0000, 16'h0000));    // zero burst
        send_job(mk(MODE_ADD, 8'hFF, 16'hFFFF, 16'hFFFF));    // never arrives
        send_job(mk(MODE_ADD, 8'h5A, 16'h0000, 16'hFFFF));
        send_job(mk(MODE_ADD, 8'h02, 16'd3, 16'd2));
        send_job(mk(MODE_ADD, 8'h03, 16'd0, 16'd2));
        send_job(mk(MODE_ADD, 8'h04, 16'd0, 16'd2));          // ties with 3 up to add order
        send_job(mk(MODE_ADD, 8'h05, 16'd1, 16'd1));
        send_job(mk(MODE_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
        repeat (3) send_job(mk(MODE_TICK, 8'h00, 16'h0000, 16'h0000));
        for (int k = 0; k < 12; k++)
            send_job(mk(MODE_ADD, 8'(16 + k), 16'd0, 16'(k + 1)));
        send_job(mk(MODE_ADD, 8'hA5, 16'd0, 16'd5));          // table full
        send_job(mk(MODE_ADD, 8'h00, 16'hFFFF, 16'h0000));    // zero burst on a full table

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            calm = (i >= 400 && i < 550);
            if (i == 800)
                stall_req = 1'b1;
            send_job(random_job(((i / 80) % 2) == 1));
        end
        jobs.valid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS srtf_process_scheduler");
        else
            $display("FAIL srtf_process_scheduler");
        $finish;
    end

    initial
    begin
        sched_result_t got;
        int            hold_left;
        bit            stall_done;
        hold_left = 0;
        stall_done = 1'b0;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
            begin
                got.status = srtf_status_t'(results.status);
                got.idle = results.idle;
                got.run_id = results.run_id;
                got.slice_start = results.slice_start;
                got.finished = results.job_finished;
                sb.match_result(got);
            end
            // one long hold-off so the block backs up and stalls its input
            if (stall_req && !stall_done)
            begin
                hold_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

endmodule
